[rtl/core/cwtt_pkg.sv]
// cwtt_pkg: shared types and constants for the critical window time tracker
// no dependencies
package cwtt_pkg;

  localparam int unsigned TaskW = 22;
  localparam int unsigned CpuW = 12;
  localparam int unsigned TimeW = 64;
  localparam logic [31:0] InWindowMask = 32'hFFFF_FFFE;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_SWITCH = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  // request travelling down the cell row
  typedef struct packed {
    cmd_t              cmd;
    logic [TimeW-1:0]  now;
    logic [TaskW-1:0]  prev_task;
    logic [TaskW-1:0]  next_task;
    logic [TaskW-1:0]  task_id;
    logic              in_window;
    logic [TimeW-1:0]  anchor;
    logic              done;      // matched or placed already
    logic              hit;       // insertion pass: no matching slot was found (tick)
    logic              close;     // this cell closed the window
    logic [TimeW-1:0]  raw;
    logic [TimeW-1:0]  off;
    logic [TimeW-1:0]  wait_ns;
  } req_t;

endpackage

[rtl/core/cwtt_cell.sv]
// cwtt_cell: one table slot; looks at the request passing by and hands it on
// depends on cwtt_pkg
module cwtt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  cwtt_pkg::req_t req_i,
  input  logic           free_before_i, // an earlier slot is free (for a tick)
  output cwtt_pkg::req_t req_o,
  output logic           free_o
);
  import cwtt_pkg::*;

  logic             valid_r, valid_nxt;
  logic [TaskW-1:0] task_r, task_nxt;
  logic [TimeW-1:0] entry_r, entry_nxt, anchor_r, anchor_nxt;
  logic [TimeW-1:0] ostart_r, ostart_nxt, otot_r, otot_nxt;
  req_t             req_r, req_nxt;
  logic [TimeW-1:0] off_sum;

  assign free_o = !valid_r;

  always_comb begin
    valid_nxt  = valid_r;
    task_nxt   = task_r;
    entry_nxt  = entry_r;
    anchor_nxt = anchor_r;
    ostart_nxt = ostart_r;
    otot_nxt   = otot_r;
    req_nxt    = req_i;
    off_sum    = otot_r + ((ostart_r != '0) ? (req_i.now - ostart_r) : '0);
    unique case (req_i.cmd)
      CMD_SWITCH: begin
        if (valid_r && task_r == req_i.prev_task) begin
          if (ostart_r == '0) ostart_nxt = req_i.now;
          if (task_r == req_i.next_task) begin
            // outgoing then incoming on the same slot
            if (((ostart_r == '0) ? req_i.now : ostart_r) != '0) begin
              otot_nxt = otot_r + (req_i.now - ((ostart_r == '0) ? req_i.now : ostart_r));
              ostart_nxt = '0;
            end
          end
        end else if (valid_r && task_r == req_i.next_task && ostart_r != '0) begin
          otot_nxt   = otot_r + (req_i.now - ostart_r);
          ostart_nxt = '0;
        end
      end
      CMD_TICK: begin
        if (!req_i.done) begin
          if (req_i.hit) begin
            // insertion pass: the first free slot opens
            if (!valid_r && !free_before_i && req_i.in_window) begin
              valid_nxt    = 1'b1;
              task_nxt     = req_i.task_id;
              entry_nxt    = req_i.now;
              anchor_nxt   = req_i.anchor;
              ostart_nxt   = '0;
              otot_nxt     = '0;
              req_nxt.done = 1'b1;
            end
          end else if (valid_r && task_r == req_i.task_id) begin
            req_nxt.done = 1'b1;
            if (!req_i.in_window) begin
              req_nxt.close   = 1'b1;
              req_nxt.raw     = req_i.now - entry_r;
              req_nxt.off     = off_sum;
              req_nxt.wait_ns = (anchor_r < entry_r) ? entry_r - anchor_r : '0;
              valid_nxt       = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      req_r.cmd <= CMD_NONE;
    end else begin
      valid_r <= valid_nxt;
      req_r   <= req_nxt;
    end
    task_r     <= task_nxt;
    entry_r    <= entry_nxt;
    anchor_r   <= anchor_nxt;
    ostart_r   <= ostart_nxt;
    otot_r     <= otot_nxt;
  end

  assign req_o = req_r;

endmodule

[rtl/core/critical_window_time_tracker.sv]
// critical_window_time_tracker: top level, cell row plus output register
// depends on cwtt_pkg and cwtt_cell
//
// usage
//   in_ channel: one request per event, op selects task switch or tick
//   out_ channel: one request per closed window with raw, corrected and wait times
//   the table is a row of TABLE_ENTRIES cells; a request walks the row one
//   cell per cycle, from the head register to the last cell
//   an in-window tick that misses takes a second pass to open the lowest free
//   slot; one event at a time
//   a switch or a non-closing tick gives no result
//   the corrected time is floored at zero in the output register
//   reset empties the table at once (valid bits clear)
//   when the receiver stalls the result waits in the output register and
//   no new event is taken until it leaves
//   the result is registered once the request leaves the last cell
module critical_window_time_tracker #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op, now_ns, prev_task, next_task, task_id, task_is_idle, window_info_ok,
  // window_word, last_preempt_ns, last_idle_ns, group_id, cpu_index, pad
  input  logic [335:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_task, out_group, out_cpu, raw_ns, corrected_ns, wait_ns, pad
  output logic [255:0] out_tdata
);
  import cwtt_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 2);

  typedef enum logic [1:0] { ST_IDLE, ST_SCAN, ST_INSERT, ST_OUT } state_t;

  state_t            state_r, state_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  req_t              head_r, head_nxt;
  logic [TaskW-1:0]  group_r;
  logic [CpuW-1:0]   cpu_r;
  req_t              chain [TABLE_ENTRIES+1];
  logic              freeb [TABLE_ENTRIES+1];
  logic              out_valid_r;
  logic [255:0]      out_data_r;
  req_t              tail;
  logic [TimeW-1:0]  corr;

  // input field unpack
  logic             f_op, f_idle, f_ok;
  logic [TimeW-1:0] f_now, f_pre, f_idl;
  logic [31:0]      f_word;
  assign f_op   = in_tdata[0];
  assign f_now  = in_tdata[64:1];
  assign f_idle = in_tdata[131];
  assign f_ok   = in_tdata[132];
  assign f_word = in_tdata[164:133];
  assign f_pre  = in_tdata[228:165];
  assign f_idl  = in_tdata[292:229];

  assign chain[0] = head_r;
  assign freeb[0] = 1'b0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    logic fr;
    cwtt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .req_i(chain[g]), .free_before_i(freeb[g]),
      .req_o(chain[g+1]), .free_o(fr)
    );
    assign freeb[g+1] = freeb[g] | fr;
  end

  assign tail = chain[TABLE_ENTRIES];
  assign corr = (tail.raw > tail.off) ? tail.raw - tail.off : '0;
  assign in_tready = (state_r == ST_IDLE) && !out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    head_nxt.cmd = CMD_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          head_nxt.now       = f_now;
          head_nxt.prev_task = in_tdata[86:65];
          head_nxt.next_task = in_tdata[108:87];
          head_nxt.task_id   = in_tdata[130:109];
          head_nxt.in_window = (f_word & InWindowMask) != '0;
          head_nxt.anchor    = (f_pre > f_idl) ? f_pre : f_idl;
          head_nxt.done      = 1'b0;
          head_nxt.hit       = 1'b0;
          head_nxt.close     = 1'b0;
          if (!f_op) begin
            head_nxt.cmd = CMD_SWITCH;
            state_nxt    = ST_SCAN;
            cnt_nxt      = '0;
          end else if (!f_idle && f_ok) begin
            head_nxt.cmd = CMD_TICK;
            state_nxt    = ST_SCAN;
            cnt_nxt      = '0;
          end
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(TABLE_ENTRIES)) begin
          cnt_nxt = '0;
          if (tail.cmd == CMD_TICK && tail.close) state_nxt = ST_OUT;
          else if (tail.cmd == CMD_TICK && !tail.done && tail.in_window) begin
            head_nxt     = tail;
            head_nxt.hit = 1'b1;
            state_nxt    = ST_INSERT;
          end else state_nxt = ST_IDLE;
        end
      end
      ST_INSERT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(TABLE_ENTRIES)) state_nxt = ST_IDLE;
      end
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      head_r.cmd  <= CMD_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      if (state_r == ST_SCAN && cnt_r == CntW'(TABLE_ENTRIES)
          && tail.cmd == CMD_TICK && tail.close) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (state_r == ST_IDLE && in_tvalid && in_tready) begin
      group_r <= in_tdata[314:293];
      cpu_r   <= in_tdata[326:315];
    end
    if (state_r == ST_SCAN && cnt_r == CntW'(TABLE_ENTRIES)) begin
      out_data_r <= {8'd0, tail.wait_ns, corr, tail.raw, cpu_r, group_r, tail.task_id};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
